@@ hw/rtl/dense_layer_forward_mac_macros.svh @@
// Assertion macros shared by the dense layer forward MAC RTL.
// Depends on nothing; files that assert include this header by name.
`ifndef DENSE_LAYER_FORWARD_MAC_MACROS_SVH
`define DENSE_LAYER_FORWARD_MAC_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DLF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DLF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dlf_pkg.sv @@
// Package for the dense layer forward MAC: sizes, codes, queue entry type.
// Depends on nothing; used by every module of the block.
`default_nettype none

package dlf_pkg;

    localparam int MAX_INPUTS  = 64;
    localparam int MAX_OUTPUTS = 64;
    localparam int DATA_W      = 16;
    localparam int ACC_W       = 40;
    localparam int FRAC_W      = DATA_W - 4;
    localparam int IN_IDX_W    = $clog2(MAX_INPUTS);
    localparam int OUT_IDX_W   = $clog2(MAX_OUTPUTS);
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int WADDR_W     = IN_IDX_W + OUT_IDX_W;
    localparam int Q_W         = ACC_W - FRAC_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input item kinds.
    typedef enum logic [1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_ELEM   = 2'd2
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_INPUTS  = 2'd0,
        REG_ACTIVE_OUTPUTS = 2'd1
    } reg_idx_t;

    // Operations passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_ELEM   = 2'd2
    } op_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_FIN_RD,
        S_FIN_SUM,
        S_FIN_OUT
    } state_t;

    typedef struct packed {
        op_t                     op;
        logic [IN_IDX_W-1:0]     in_idx;
        logic [OUT_IDX_W-1:0]    out_idx;
        logic signed [DATA_W-1:0] value;
        logic                    last;
    } entry_t;

    // Queue status seen by the back end: empty flag and head entry.
    typedef struct packed {
        logic   empty;
        entry_t head;
    } queue_stat_t;

    // Clamp a count register to 1..max.
    function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                     input logic [CFG_W-1:0] max);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > max) begin
            r = max;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dlf_front.sv @@
// Front end: configuration registers and classification of input items.
// Depends on dlf_pkg.
`default_nettype none

module dlf_front
    import dlf_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_kind,
    input  wire logic [IN_IDX_W-1:0]      s_input_index,
    input  wire logic [OUT_IDX_W-1:0]     s_output_index,
    input  wire logic signed [DATA_W-1:0] s_value,
    input  wire logic                     q_full,
    output logic                          q_push,
    output entry_t                        q_entry,
    output logic [CFG_W-1:0]              active_outputs
);

    localparam logic [CFG_W-1:0] MaxIn  = CFG_W'(MAX_INPUTS);
    localparam logic [CFG_W-1:0] MaxOut = CFG_W'(MAX_OUTPUTS);

    logic [CFG_W-1:0] act_in_reg;
    logic [CFG_W-1:0] act_out_reg;
    logic             keep;
    logic [CFG_W-1:0] idx_ext;

    // Count registers, clamped on write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_in_reg  <= MaxIn;
            act_out_reg <= MaxOut;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_ACTIVE_INPUTS:  act_in_reg  <= clamp_count(cfg_data, MaxIn);
                REG_ACTIVE_OUTPUTS: act_out_reg <= clamp_count(cfg_data, MaxOut);
                default: ;
            endcase
        end
    end

    assign active_outputs = act_out_reg;
    assign idx_ext        = CFG_W'(s_input_index);

    // Classify the item; unknown kinds and elements past the vector are dropped.
    always_comb begin
        q_entry.in_idx  = s_input_index;
        q_entry.out_idx = s_output_index;
        q_entry.value   = s_value;
        q_entry.last    = (idx_ext == act_in_reg - CFG_W'(1));
        case (kind_t'(s_kind))
            KIND_WEIGHT: begin
                q_entry.op = OP_WEIGHT;
                keep       = 1'b1;
            end
            KIND_BIAS: begin
                q_entry.op = OP_BIAS;
                keep       = 1'b1;
            end
            KIND_ELEM: begin
                q_entry.op = OP_ELEM;
                keep       = (idx_ext < act_in_reg);
            end
            default: begin
                q_entry.op = OP_ELEM;
                keep       = 1'b0;
            end
        endcase
    end

    // A transfer completes whenever the queue has room; dropped items just vanish.
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready && keep;

endmodule

`default_nettype wire

@@ hw/rtl/dlf_queue.sv @@
// Short queue of classified items between the front end and the back end.
// Depends on dlf_pkg.
`default_nettype none

module dlf_queue
    import dlf_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  entry_t      push_entry,
    output logic        full,
    input  wire logic   pop,
    output queue_stat_t stat
);

    entry_t            store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.head  = store_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ hw/rtl/dlf_back.sv @@
// Back end: weight, bias and accumulator memories, MAC pipeline and output stage.
// Depends on dlf_pkg and dense_layer_forward_mac_macros.svh.
`default_nettype none
`include "dense_layer_forward_mac_macros.svh"

module dlf_back
    import dlf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  queue_stat_t             q_stat,
    output logic                    q_pop,
    input  wire logic [CFG_W-1:0]   active_outputs,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [OUT_IDX_W-1:0]    m_neuron,
    output logic signed [DATA_W-1:0] m_activation,
    output logic                    m_clipped,
    output logic                    m_last
);

    localparam int SatW = Q_W - DATA_W + 1;

    // Sequencer.
    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     j_reg, j_next;
    logic [IN_IDX_W-1:0]  cur_ii_reg;
    logic signed [DATA_W-1:0] cur_val_reg;
    logic                 cur_last_reg;
    logic                 issue;
    logic                 out_load;
    logic                 acc_clear;
    logic                 j_at_end;

    // Memories.
    logic signed [DATA_W-1:0] wmem [MAX_INPUTS*MAX_OUTPUTS];
    logic signed [DATA_W-1:0] bmem [MAX_OUTPUTS];
    logic [ACC_W-1:0]         amem [MAX_OUTPUTS];
    logic [MAX_OUTPUTS-1:0]   acc_valid_reg;
    logic signed [DATA_W-1:0] w_rd_reg;
    logic signed [DATA_W-1:0] b_rd_reg;
    logic [ACC_W-1:0]         a_rd_reg;
    logic                     av_rd_reg;
    logic                     w_we;
    logic                     b_we;
    logic                     a_we;
    logic [OUT_IDX_W-1:0]     rd_j;

    // MAC pipeline.
    logic                     p1_valid_reg;
    logic [OUT_IDX_W-1:0]     p1_j_reg;
    logic                     p2_valid_reg;
    logic [OUT_IDX_W-1:0]     p2_j_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic [ACC_W-1:0]         acc_d_reg;
    logic [ACC_W-1:0]         acc_sum;
    logic [ACC_W-1:0]         acc_eff;

    // Finalize path.
    logic [ACC_W-1:0]         fin_sum_reg;
    logic [ACC_W-1:0]         bias_ext;
    logic [Q_W-1:0]           q_val;
    logic [SatW-1:0]          q_top;
    logic                     sat;
    logic signed [DATA_W-1:0] act_val;

    // Output register.
    logic                     m_valid_reg;
    logic [OUT_IDX_W-1:0]     m_neuron_reg;
    logic signed [DATA_W-1:0] m_act_reg;
    logic                     m_clip_reg;
    logic                     m_last_reg;

    assign rd_j     = j_reg[OUT_IDX_W-1:0];
    assign j_at_end = (j_reg == active_outputs - CFG_W'(1));
    assign w_we     = (state_reg == S_IDLE) && !q_stat.empty && (q_stat.head.op == OP_WEIGHT);
    assign b_we     = (state_reg == S_IDLE) && !q_stat.empty && (q_stat.head.op == OP_BIAS);
    assign a_we     = p2_valid_reg;
    assign acc_eff  = av_rd_reg ? a_rd_reg : '0;

    // Weight memory: one write port for loads, one registered read port for the MAC.
    always_ff @(posedge aclk) begin
        if (w_we) begin
            wmem[{q_stat.head.in_idx, q_stat.head.out_idx}] <= q_stat.head.value;
        end
        w_rd_reg <= wmem[{cur_ii_reg, rd_j}];
    end

    // Bias memory.
    always_ff @(posedge aclk) begin
        if (b_we) begin
            bmem[q_stat.head.out_idx] <= q_stat.head.value;
        end
        b_rd_reg <= bmem[rd_j];
    end

    // Accumulator memory; written from the last MAC stage.
    always_ff @(posedge aclk) begin
        if (a_we) begin
            amem[p2_j_reg] <= acc_sum;
        end
        a_rd_reg <= amem[rd_j];
    end

    // Accumulator valid bits: an entry not written since the last clear reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= '0;
            av_rd_reg     <= 1'b0;
        end else begin
            av_rd_reg <= acc_valid_reg[rd_j];
            if (acc_clear) begin
                acc_valid_reg <= '0;
            end else if (a_we) begin
                acc_valid_reg[p2_j_reg] <= 1'b1;
            end
        end
    end

    // MAC pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // MAC pipeline data: multiply, then add in the following cycle.
    always_ff @(posedge aclk) begin
        p1_j_reg  <= rd_j;
        p2_j_reg  <= p1_j_reg;
        prod_reg  <= cur_val_reg * w_rd_reg;
        acc_d_reg <= acc_eff;
    end

    assign acc_sum = acc_d_reg + {{(ACC_W-2*DATA_W){prod_reg[2*DATA_W-1]}}, prod_reg};

    // Finalize: add the bias scaled to the accumulator format.
    assign bias_ext = {{(ACC_W-DATA_W-FRAC_W){b_rd_reg[DATA_W-1]}}, b_rd_reg, {FRAC_W{1'b0}}};

    always_ff @(posedge aclk) begin
        fin_sum_reg <= acc_eff + bias_ext;
    end

    // Floor shift is the upper slice; saturate when it does not fit the output width.
    assign q_val = fin_sum_reg[ACC_W-1:FRAC_W];
    assign q_top = q_val[Q_W-1:DATA_W-1];
    assign sat   = !((&q_top) || !(|q_top));

    always_comb begin
        if (!sat) begin
            act_val = q_val[DATA_W-1:0];
        end else if (q_val[Q_W-1]) begin
            act_val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            act_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // Sequencer state and item registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_ii_reg   <= q_stat.head.in_idx;
            cur_val_reg  <= q_stat.head.value;
            cur_last_reg <= q_stat.head.last;
        end
    end

    // Next state: loads finish in the idle state, an element runs one MAC pass,
    // and the last element of a vector then streams out one result per output.
    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        q_pop      = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        acc_clear  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop = 1'b1;
                    if (q_stat.head.op == OP_ELEM) begin
                        j_next     = '0;
                        state_next = S_MAC;
                    end
                end
            end
            S_MAC: begin
                issue = 1'b1;
                if (j_at_end) begin
                    j_next     = '0;
                    state_next = S_DRAIN;
                end else begin
                    j_next = j_reg + CFG_W'(1);
                end
            end
            S_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg) begin
                    state_next = cur_last_reg ? S_FIN_RD : S_IDLE;
                end
            end
            S_FIN_RD: begin
                state_next = S_FIN_SUM;
            end
            S_FIN_SUM: begin
                state_next = S_FIN_OUT;
            end
            S_FIN_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    if (j_at_end) begin
                        acc_clear  = 1'b1;
                        j_next     = '0;
                        state_next = S_IDLE;
                    end else begin
                        j_next     = j_reg + CFG_W'(1);
                        state_next = S_FIN_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_neuron_reg <= rd_j;
            m_act_reg    <= act_val;
            m_clip_reg   <= sat;
            m_last_reg   <= j_at_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_neuron     = m_neuron_reg;
    assign m_activation = m_act_reg;
    assign m_clipped    = m_clip_reg;
    assign m_last       = m_last_reg;

    // The queue is only popped by an idle sequencer.
    `DLF_ASSERT_SAME(a_pop_idle, aclk, aresetn, q_pop, state_reg == S_IDLE, "pop outside idle")
    // The MAC pipeline has drained before any accumulator is finalized.
    `DLF_ASSERT_SAME(a_fin_drained, aclk, aresetn, state_reg == S_FIN_RD,
                     !p1_valid_reg && !p2_valid_reg, "finalize with MAC in flight")
    // The last result of a vector leaves every accumulator cleared.
    `DLF_ASSERT_NEXT(a_acc_cleared, aclk, aresetn, out_load && j_at_end,
                     acc_valid_reg == '0 && m_last_reg, "accumulators not cleared")
    // Every accumulator write comes from an earlier issue, through the p1 and p2 stages.
    `DLF_ASSERT_SAME(a_pipe_order, aclk, aresetn, p2_valid_reg,
                     $past(issue, 2), "MAC write without issue")

endmodule

`default_nettype wire

@@ hw/rtl/dense_layer_forward_mac.sv @@
// Top level of the fully connected layer forward MAC.
// Depends on dlf_pkg, dlf_front, dlf_queue and dlf_back.
//
// Usage: the s_ channel carries weight loads (kind 0), bias loads (kind 1)
// and input vector elements (kind 2) as valid/ready transfers. The m_ channel
// returns one result per active output neuron after the element at position
// active_inputs-1 arrives, in neuron order, with m_last on the final one.
// The count registers are written through cfg_wr_en, cfg_index and cfg_data
// while the block is idle; a value of zero acts as one, a value above the
// maximum as the maximum.
// Structure: a four-entry queue parts the front end from the back end. A weight
// or bias load is written in the back end's idle state. An element runs
// through the single multiply-accumulate pipeline, which visits one output per
// cycle. After the last element, each result passes through the accumulator
// read, bias add and output load states in turn.
// Reset clears the queue, the output register, the sequencer and all
// accumulators at once; the weight and bias memories keep their contents and
// must be loaded before use. A stalled receiver holds the result in the
// output register and pauses the back end; the queue keeps taking items until
// it fills.
`default_nettype none

module dense_layer_forward_mac
    import dlf_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_kind,
    input  wire logic [IN_IDX_W-1:0]      s_input_index,
    input  wire logic [OUT_IDX_W-1:0]     s_output_index,
    input  wire logic signed [DATA_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [OUT_IDX_W-1:0]          m_neuron,
    output logic signed [DATA_W-1:0]      m_activation,
    output logic                          m_clipped,
    output logic                          m_last
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    entry_t           q_entry;
    queue_stat_t      q_stat;
    logic [CFG_W-1:0] active_outputs;

    // Front end: configuration and classification.
    dlf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_input_index  (s_input_index),
        .s_output_index (s_output_index),
        .s_value        (s_value),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_entry),
        .active_outputs (active_outputs)
    );

    // Queue between the two halves.
    dlf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .stat       (q_stat)
    );

    // Back end: memories, MAC pipeline and result stage.
    dlf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .q_pop          (q_pop),
        .active_outputs (active_outputs),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_neuron       (m_neuron),
        .m_activation   (m_activation),
        .m_clipped      (m_clipped),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire
